// ===== src/apsc_pkg.sv =====
// ============================================================================
// apsc_pkg - shared types and constants of the polynomial soft clipper
//
// Item structs, curve codes, register indexes, a rounding helper and the
// fixed-point constants that the pipeline sections use.
// ============================================================================
package apsc_pkg;

    localparam int SAMPLE_W   = 24;   // Q4.19 sample width
    localparam int GAIN_W     = 24;   // Q8.16 gain width
    localparam int MODE_W     = 5;    // curve select width
    localparam int CFG_IDX_W  = 1;    // register index width
    localparam int CFG_DATA_W = 24;   // widest register
    localparam int Q_W        = 24;   // Q1.22 working value width
    localparam int NUM_W      = 29;   // curve numerator width
    localparam int Y_W        = 28;   // shaped value width before output rounding
    localparam int DV_W       = 3;    // finishing-operation code width
    localparam int RND_W      = 56;   // width of the rounding helper

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 1'b1;

    // Curve codes.
    localparam logic [MODE_W-1:0] MODE_OFF   = 5'd0;
    localparam logic [MODE_W-1:0] MODE_HARD  = 5'd1;
    localparam logic [MODE_W-1:0] MODE_FR2   = 5'd2;
    localparam logic [MODE_W-1:0] MODE_FR6   = 5'd3;
    localparam logic [MODE_W-1:0] MODE_HR2   = 5'd4;
    localparam logic [MODE_W-1:0] MODE_HR6   = 5'd5;
    localparam logic [MODE_W-1:0] MODE_DS2   = 5'd6;
    localparam logic [MODE_W-1:0] MODE_DS2B  = 5'd7;
    localparam logic [MODE_W-1:0] MODE_DPGM  = 5'd8;
    localparam logic [MODE_W-1:0] MODE_DM3   = 5'd9;
    localparam logic [MODE_W-1:0] MODE_DM4   = 5'd10;
    localparam logic [MODE_W-1:0] MODE_DM4_2 = 5'd11;
    localparam logic [MODE_W-1:0] MODE_SA3   = 5'd12;
    localparam logic [MODE_W-1:0] MODE_SA4   = 5'd13;
    localparam logic [MODE_W-1:0] MODE_SA4_2 = 5'd14;
    localparam logic [MODE_W-1:0] MODE_SAE   = 5'd15;
    localparam logic [MODE_W-1:0] MODE_SA5   = 5'd16;

    // How a curve numerator is finished into a Q1.22 value.
    localparam logic [DV_W-1:0] DV_NONE  = 3'd0;
    localparam logic [DV_W-1:0] DV_SH1   = 3'd1;
    localparam logic [DV_W-1:0] DV_SH2   = 3'd2;
    localparam logic [DV_W-1:0] DV_SH3   = 3'd3;
    localparam logic [DV_W-1:0] DV_DIV9  = 3'd4;
    localparam logic [DV_W-1:0] DV_DIV12 = 3'd5;
    localparam logic [DV_W-1:0] DV_HR6   = 3'd6;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 24'sd65536;    // 1.0 in Q8.16
    localparam logic signed [Q_W-1:0]    Q_ONE      = 24'sd4194304;  // 1.0 in Q1.22
    localparam logic signed [Q_W-1:0]    HR6_C2     = 24'sd1982814;
    localparam logic signed [Q_W-1:0]    HR6_C1     = 24'sd228676;   // one minus twice c2

    // Floor reciprocals scaled by 2^32; one correction step follows them.
    localparam logic [28:0] RECIP_9  = 29'd477218588;
    localparam logic [28:0] RECIP_12 = 29'd357913941;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       block_last_out;
    } t_out_item;

    // Control that travels down the pipeline beside each item.
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic                       pass;   // item leaves unchanged
        logic                       gneg;   // negate the shaped value at the end
        logic [MODE_W-1:0]          mode;
        logic signed [SAMPLE_W-1:0] s;      // original sample for pass-through
    } t_ctl;

    // Arithmetic shift right by n with round to nearest, ties away from zero.
    function automatic logic signed [RND_W-1:0] rnd_shr(
        input logic signed [RND_W-1:0] v,
        input logic [5:0]              n
    );
        logic signed [RND_W-1:0] half;
        logic signed [RND_W-1:0] sum;
        half = 56'sd1 <<< (n - 6'd1);
        sum  = v + half - RND_W'(v[RND_W-1]);
        return sum >>> n;
    endfunction

endpackage

// ===== src/audio_polynomial_soft_clipper.sv =====
// ============================================================================
// audio_polynomial_soft_clipper - gain, clamp and polynomial waveshaping
//
// Fully pipelined per-sample soft clipper with a plain register write port.
// ============================================================================
// How to use this block:
// Configuration goes through a write port: i_cfg_we, i_cfg_idx and
// i_cfg_data. Index 0 holds the 5-bit curve select and index 1 the signed
// Q8.16 drive gain. Write them only while no item is in flight.
// An item (one Q4.19 sample and its end-of-buffer mark) is taken at every
// rising edge with start high and busy low. busy never rises: the pipeline
// takes a new item in every clock cycle, so the sustained rate is one item
// per cycle.
// Each item gives exactly one result on o_out, marked by o_strobe for one
// cycle. The result passes through eleven register stages (input register
// with the effective gain, gain product, clamp, four stages of power
// products, the curve sum, the reciprocal division in two stages, and the
// output register).
// The receiver cannot stall, and none is needed: the result is simply on
// the port for one cycle. Results leave in the order items came in.
// A synchronous reset (i_rst_n low) drops every item in flight, clears
// o_strobe and returns the curve select to off and the gain to 1.0.
// ============================================================================
module audio_polynomial_soft_clipper (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  apsc_pkg::t_in_item                   i_in,
    input  logic                                 i_cfg_we,
    input  logic [apsc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [apsc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_strobe,
    output apsc_pkg::t_out_item                  o_out
);
    import apsc_pkg::*;

    // Configuration registers.
    logic [MODE_W-1:0]          r_mode;
    logic signed [GAIN_W-1:0]   r_gain;

    // Stage A: registered item with the effective gain.
    t_ctl                       r_a_ctl, n_a_ctl;
    logic signed [GAIN_W:0]     r_a_g, n_a_g;
    logic                       w_accept, w_abs, w_pass;

    // Stage B: full Q12.35 product.
    t_ctl                       r_b_ctl;
    logic signed [48:0]         r_b_p;

    // Stage C: clamped and rounded Q1.22 value.
    t_ctl                       r_x_ctl;
    logic signed [Q_W-1:0]      r_x;
    logic signed [48:0]         w_pc;
    logic signed [RND_W-1:0]    w_x_full;

    // Curve and division sections.
    t_ctl                       w_cur_ctl, w_div_ctl;
    logic signed [NUM_W-1:0]    w_num;
    logic [DV_W-1:0]            w_dsel;
    logic signed [Q_W-1:0]      w_m5;
    logic signed [Y_W-1:0]      w_y;

    // Output stage.
    logic signed [Y_W-1:0]      w_ys;
    logic signed [RND_W-1:0]    w_yr;
    t_out_item                  r_out, n_out;
    logic                       r_strobe;

    localparam logic signed [48:0] P_LIM = 49'sh8_0000_0000;   // 1.0 in Q12.35

    // Every cycle can take an item.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CURVE_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                REG_DRIVE_GAIN: r_gain <= GAIN_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Hard, sa3 and sa5 run on the gain magnitude and keep the curve's own
    // sign; every other curve uses the signed gain and flips its output when
    // the gain is negative. Unused codes pass the sample through.
    always_comb begin
        w_abs   = r_mode inside {MODE_HARD, MODE_SA3, MODE_SA5};
        w_pass  = (r_mode == MODE_OFF) || (r_mode > MODE_SA5);
        n_a_g   = (w_abs && r_gain[GAIN_W-1]) ? -(GAIN_W+1)'(r_gain) : (GAIN_W+1)'(r_gain);
        n_a_ctl.valid = w_accept;
        n_a_ctl.last  = i_in.block_last_in;
        n_a_ctl.pass  = w_pass;
        n_a_ctl.gneg  = !w_abs && r_gain[GAIN_W-1];
        n_a_ctl.mode  = r_mode;
        n_a_ctl.s     = i_in.sample_in;
    end

    // Overdrive saturates at plus or minus one before rounding to Q1.22.
    assign w_pc = (r_b_p > P_LIM) ? P_LIM : ((r_b_p < -P_LIM) ? -P_LIM : r_b_p);
    assign w_x_full = rnd_shr(RND_W'(w_pc), 6'd13);

    always_ff @(posedge i_clk) begin
        r_a_ctl <= n_a_ctl;
        r_a_g   <= n_a_g;

        r_b_ctl <= r_a_ctl;
        r_b_p   <= r_a_ctl.s * r_a_g;

        r_x_ctl <= r_b_ctl;
        r_x     <= w_x_full[Q_W-1:0];

        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
            r_b_ctl.valid <= 1'b0;
            r_x_ctl.valid <= 1'b0;
        end
    end

    apsc_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_x_ctl),
        .i_x     (r_x),
        .o_ctl   (w_cur_ctl),
        .o_num   (w_num),
        .o_dsel  (w_dsel),
        .o_m5    (w_m5)
    );

    apsc_rdiv u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cur_ctl),
        .i_num   (w_num),
        .i_dsel  (w_dsel),
        .i_m5    (w_m5),
        .o_ctl   (w_div_ctl),
        .o_y     (w_y)
    );

    // Output sign, then Q1.22 to Q4.19 with rounding; the result wraps to
    // the 24-bit output field.
    assign w_ys = w_div_ctl.gneg ? -w_y : w_y;
    assign w_yr = rnd_shr(RND_W'(w_ys), 6'd3);

    always_comb begin
        n_out.block_last_out = w_div_ctl.last;
        n_out.sample_out     = w_div_ctl.pass ? w_div_ctl.s : w_yr[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_strobe <= w_div_ctl.valid;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end
    end

    assign o_out    = r_out;
    assign o_strobe = r_strobe;

    // Every accepted item comes out as a result on o_strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##11 o_strobe)
        else $error("apsc: accepted item did not produce a result on time");

    // No result appears without a matching accepted item.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 11))
        else $error("apsc: result without a matching item");

    // The clamp keeps the shaping input within plus or minus one.
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_ctl.valid |-> (r_x <= Q_ONE) && (r_x >= -Q_ONE))
        else $error("apsc: clamped value out of range");

endmodule

// ===== src/apsc_curve.sv =====
// ============================================================================
// apsc_curve - power chain and curve numerator
//
// Forms the rounded powers of the clamped Q1.22 value over four stages and
// combines them into the selected curve's numerator in a fifth stage.
// ============================================================================
module apsc_curve (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  apsc_pkg::t_ctl                        i_ctl,
    input  logic signed [apsc_pkg::Q_W-1:0]       i_x,
    output apsc_pkg::t_ctl                        o_ctl,
    output logic signed [apsc_pkg::NUM_W-1:0]     o_num,
    output logic [apsc_pkg::DV_W-1:0]             o_dsel,
    output logic signed [apsc_pkg::Q_W-1:0]       o_m5
);
    import apsc_pkg::*;

    // Stage E: square.
    t_ctl                    r_e_ctl;
    logic signed [Q_W-1:0]   r_e_x, r_e_x2;
    logic signed [47:0]      w_xx;
    logic signed [RND_W-1:0] w_e_x2;

    // Stage F: cube, fourth power, x - x^2.
    t_ctl                    r_f_ctl;
    logic signed [Q_W-1:0]   r_f_x, r_f_x2, r_f_x3, r_f_x4;
    logic signed [24:0]      r_f_tmp;
    logic signed [47:0]      w_x3p, w_x4p;
    logic signed [RND_W-1:0] w_f_x3, w_f_x4;
    logic signed [24:0]      n_f_tmp;

    // Stage G: fifth and sixth powers, (x - x^2)^2, 3x - x^3.
    t_ctl                    r_g_ctl;
    logic signed [Q_W-1:0]   r_g_x, r_g_x2, r_g_x3, r_g_x4, r_g_x5, r_g_x6;
    logic signed [25:0]      r_g_tt, r_g_t3;
    logic signed [47:0]      w_x5p, w_x6p;
    logic signed [49:0]      w_ttp;
    logic signed [RND_W-1:0] w_g_x5, w_g_x6, w_g_tt;
    logic signed [25:0]      n_g_t3;

    // Stage H: squared cubic and the product used by the dpgm curve.
    t_ctl                    r_h_ctl;
    logic signed [Q_W-1:0]   r_h_x, r_h_x2, r_h_x3, r_h_x4, r_h_x5, r_h_x6, r_h_low;
    logic signed [25:0]      r_h_t3, r_h_t8;
    logic signed [51:0]      w_lowp;
    logic signed [49:0]      w_t8p;
    logic signed [RND_W-1:0] w_h_low, w_h_t8;

    // Stage I: numerator and hr6 product.
    t_ctl                    r_i_ctl;
    logic signed [NUM_W-1:0] r_i_num, n_i_num;
    logic [DV_W-1:0]         r_i_dsel, n_i_dsel;
    logic signed [Q_W-1:0]   r_i_m5;
    logic signed [24:0]      w_xl;
    logic signed [49:0]      w_m5p;
    logic signed [RND_W-1:0] w_i_m5;
    logic signed [NUM_W-1:0] e_one, e_x, e_x2, e_x3, e_x4, e_x5, e_x6, e_low, e_t3, e_t8;

    assign w_xx   = i_x * i_x;
    assign w_e_x2 = rnd_shr(RND_W'(w_xx), 6'd22);

    assign w_x3p   = r_e_x2 * r_e_x;
    assign w_x4p   = r_e_x2 * r_e_x2;
    assign w_f_x3  = rnd_shr(RND_W'(w_x3p), 6'd22);
    assign w_f_x4  = rnd_shr(RND_W'(w_x4p), 6'd22);
    assign n_f_tmp = 25'(r_e_x) - 25'(r_e_x2);

    assign w_x5p  = r_f_x4 * r_f_x;
    assign w_x6p  = r_f_x4 * r_f_x2;
    assign w_ttp  = r_f_tmp * r_f_tmp;
    assign w_g_x5 = rnd_shr(RND_W'(w_x5p), 6'd22);
    assign w_g_x6 = rnd_shr(RND_W'(w_x6p), 6'd22);
    assign w_g_tt = rnd_shr(RND_W'(w_ttp), 6'd22);
    assign n_g_t3 = (26'(r_f_x) <<< 1) + 26'(r_f_x) - 26'(r_f_x3);

    assign w_lowp  = r_g_t3 * r_g_t3;
    assign w_t8p   = r_g_x2 * r_g_tt;
    assign w_h_low = rnd_shr(RND_W'(w_lowp), 6'd24);
    assign w_h_t8  = rnd_shr(RND_W'(w_t8p), 6'd22);

    assign w_xl   = 25'(r_h_x) + 25'(r_h_low);
    assign w_m5p  = w_xl * 25'(HR6_C2);
    assign w_i_m5 = rnd_shr(RND_W'(w_m5p), 6'd22);

    assign e_one = NUM_W'(Q_ONE);
    assign e_x   = NUM_W'(r_h_x);
    assign e_x2  = NUM_W'(r_h_x2);
    assign e_x3  = NUM_W'(r_h_x3);
    assign e_x4  = NUM_W'(r_h_x4);
    assign e_x5  = NUM_W'(r_h_x5);
    assign e_x6  = NUM_W'(r_h_x6);
    assign e_low = NUM_W'(r_h_low);
    assign e_t3  = NUM_W'(r_h_t3);
    assign e_t8  = NUM_W'(r_h_t8);

    // Each curve as an integer combination of powers over a small divisor.
    always_comb begin
        n_i_num  = e_x;
        n_i_dsel = DV_NONE;
        case (r_h_ctl.mode)
            MODE_FR2: begin
                n_i_num = (e_x2 <<< 1) - e_one;
            end
            MODE_FR6: begin
                n_i_num = (e_low <<< 1) - e_one;
            end
            MODE_HR2: begin
                n_i_num  = e_one + (e_x <<< 2) + (e_x2 <<< 2);
                n_i_dsel = DV_DIV9;
            end
            MODE_HR6: begin
                n_i_num  = '0;
                n_i_dsel = DV_HR6;
            end
            MODE_DS2: begin
                n_i_num  = e_one + (e_x <<< 1) - e_x2;
                n_i_dsel = DV_SH1;
            end
            MODE_DS2B: begin
                n_i_num  = 29'sd3 * e_one + 29'sd3 * e_x - 29'sd3 * e_x2 + e_x3;
                n_i_dsel = DV_SH2;
            end
            MODE_DPGM: begin
                n_i_num  = (e_one <<< 1) + 29'sd14 * e_x - (e_x2 <<< 2) + e_t8;
                n_i_dsel = DV_DIV12;
            end
            MODE_DM3: begin
                n_i_num  = e_one + 29'sd3 * e_x - e_x2 + e_x3;
                n_i_dsel = DV_SH2;
            end
            MODE_DM4: begin
                n_i_num  = (e_x <<< 3) - e_one - (e_x2 <<< 1) + 29'sd3 * e_x4;
                n_i_dsel = DV_SH3;
            end
            MODE_DM4_2: begin
                n_i_num  = 29'sd5 * e_x - e_x2 - e_x3 + e_x4;
                n_i_dsel = DV_SH2;
            end
            MODE_SA3: begin
                n_i_num  = e_t3;
                n_i_dsel = DV_SH1;
            end
            MODE_SA4: begin
                n_i_num  = e_one + 29'sd12 * e_x - (e_x2 <<< 1) - (e_x3 <<< 2) + e_x4;
                n_i_dsel = DV_SH3;
            end
            MODE_SA4_2: begin
                n_i_num  = e_one + 29'sd6 * e_x - (e_x2 <<< 1) - (e_x3 <<< 1) + e_x4;
                n_i_dsel = DV_SH2;
            end
            MODE_SAE: begin
                n_i_num  = (e_x <<< 2) - e_x2 + (e_x4 <<< 1) - e_x6;
                n_i_dsel = DV_SH2;
            end
            MODE_SA5: begin
                n_i_num  = 29'sd15 * e_x - 29'sd10 * e_x3 + 29'sd3 * e_x5;
                n_i_dsel = DV_SH3;
            end
            default: begin
                // Hard clip, and pass-through items whose value is replaced later.
                n_i_num  = e_x;
                n_i_dsel = DV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_e_ctl <= i_ctl;
        r_e_x   <= i_x;
        r_e_x2  <= w_e_x2[Q_W-1:0];

        r_f_ctl <= r_e_ctl;
        r_f_x   <= r_e_x;
        r_f_x2  <= r_e_x2;
        r_f_x3  <= w_f_x3[Q_W-1:0];
        r_f_x4  <= w_f_x4[Q_W-1:0];
        r_f_tmp <= n_f_tmp;

        r_g_ctl <= r_f_ctl;
        r_g_x   <= r_f_x;
        r_g_x2  <= r_f_x2;
        r_g_x3  <= r_f_x3;
        r_g_x4  <= r_f_x4;
        r_g_x5  <= w_g_x5[Q_W-1:0];
        r_g_x6  <= w_g_x6[Q_W-1:0];
        r_g_tt  <= w_g_tt[25:0];
        r_g_t3  <= n_g_t3;

        r_h_ctl <= r_g_ctl;
        r_h_x   <= r_g_x;
        r_h_x2  <= r_g_x2;
        r_h_x3  <= r_g_x3;
        r_h_x4  <= r_g_x4;
        r_h_x5  <= r_g_x5;
        r_h_x6  <= r_g_x6;
        r_h_t3  <= r_g_t3;
        r_h_low <= w_h_low[Q_W-1:0];
        r_h_t8  <= w_h_t8[25:0];

        r_i_ctl  <= r_h_ctl;
        r_i_num  <= n_i_num;
        r_i_dsel <= n_i_dsel;
        r_i_m5   <= w_i_m5[Q_W-1:0];

        if (!i_rst_n) begin
            r_e_ctl.valid <= 1'b0;
            r_f_ctl.valid <= 1'b0;
            r_g_ctl.valid <= 1'b0;
            r_h_ctl.valid <= 1'b0;
            r_i_ctl.valid <= 1'b0;
        end
    end

    assign o_ctl  = r_i_ctl;
    assign o_num  = r_i_num;
    assign o_dsel = r_i_dsel;
    assign o_m5   = r_i_m5;

    // A square of a value within plus or minus one stays within zero and one.
    a_x2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_ctl.valid |-> (r_e_x2 >= 24'sd0) && (r_e_x2 <= Q_ONE))
        else $error("apsc_curve: square out of range");

endmodule

// ===== src/apsc_rdiv.sv =====
// ============================================================================
// apsc_rdiv - rounded finishing of the curve numerator
//
// Divides by 9 or 12 (reciprocal product, one correction step), rounds a
// shift by 1 to 3 bits, or adds the hr6 offset; ties round away from zero.
// ============================================================================
module apsc_rdiv (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  apsc_pkg::t_ctl                        i_ctl,
    input  logic signed [apsc_pkg::NUM_W-1:0]     i_num,
    input  logic [apsc_pkg::DV_W-1:0]             i_dsel,
    input  logic signed [apsc_pkg::Q_W-1:0]       i_m5,
    output apsc_pkg::t_ctl                        o_ctl,
    output logic signed [apsc_pkg::Y_W-1:0]       o_y
);
    import apsc_pkg::*;

    // Stage J: magnitude, bias and reciprocal product; shift cases finish here.
    t_ctl                    r_j_ctl;
    logic [56:0]             r_j_prod;
    logic [Y_W-1:0]          r_j_a;
    logic                    r_j_neg, r_j_div, r_j_d12;
    logic signed [Y_W-1:0]   r_j_dir;
    logic                    w_neg, w_div, w_d12;
    logic [Y_W-1:0]          w_mag, w_a;
    logic [28:0]             w_recip;
    logic [56:0]             w_prod;
    logic signed [RND_W-1:0] w_r1, w_r2, w_r3;
    logic signed [Y_W-1:0]   n_j_dir;

    // Stage K: quotient correction and sign.
    t_ctl                    r_k_ctl;
    logic signed [Y_W-1:0]   r_k_y;
    logic [24:0]             w_q0, w_q;
    logic [Y_W-1:0]          w_dq, w_rem, w_d;
    logic signed [Y_W-1:0]   n_k_y;

    assign w_neg   = i_num[NUM_W-1];
    assign w_mag   = w_neg ? Y_W'(-i_num) : Y_W'(i_num);
    assign w_div   = (i_dsel == DV_DIV9) || (i_dsel == DV_DIV12);
    assign w_d12   = (i_dsel == DV_DIV12);
    assign w_a     = w_mag + (w_d12 ? 28'd6 : 28'd4);
    assign w_recip = w_d12 ? RECIP_12 : RECIP_9;
    assign w_prod  = w_a * w_recip;

    assign w_r1 = rnd_shr(RND_W'(i_num), 6'd1);
    assign w_r2 = rnd_shr(RND_W'(i_num), 6'd2);
    assign w_r3 = rnd_shr(RND_W'(i_num), 6'd3);

    always_comb begin
        case (i_dsel)
            DV_SH1:  n_j_dir = w_r1[Y_W-1:0];
            DV_SH2:  n_j_dir = w_r2[Y_W-1:0];
            DV_SH3:  n_j_dir = w_r3[Y_W-1:0];
            DV_HR6:  n_j_dir = Y_W'(HR6_C1) + Y_W'(i_m5);
            default: n_j_dir = Y_W'(i_num);
        endcase
    end

    // The floor reciprocal leaves the estimate at most one below the quotient.
    assign w_q0  = r_j_prod[56:32];
    assign w_dq  = r_j_d12 ? ((Y_W'(w_q0) << 3) + (Y_W'(w_q0) << 2))
                           : ((Y_W'(w_q0) << 3) + Y_W'(w_q0));
    assign w_d   = r_j_d12 ? 28'd12 : 28'd9;
    assign w_rem = r_j_a - w_dq;
    assign w_q   = w_q0 + 25'(w_rem >= w_d);
    assign n_k_y = r_j_div ? (r_j_neg ? -Y_W'(w_q) : Y_W'(w_q)) : r_j_dir;

    always_ff @(posedge i_clk) begin
        r_j_ctl  <= i_ctl;
        r_j_prod <= w_prod;
        r_j_a    <= w_a;
        r_j_neg  <= w_neg;
        r_j_div  <= w_div;
        r_j_d12  <= w_d12;
        r_j_dir  <= n_j_dir;

        r_k_ctl  <= r_j_ctl;
        r_k_y    <= n_k_y;

        if (!i_rst_n) begin
            r_j_ctl.valid <= 1'b0;
            r_k_ctl.valid <= 1'b0;
        end
    end

    assign o_ctl = r_k_ctl;
    assign o_y   = r_k_y;

    // One correction must be enough: the remainder is below twice the divisor.
    a_one_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_j_ctl.valid && r_j_div) |-> (w_rem < (w_d << 1)))
        else $error("apsc_rdiv: reciprocal estimate off by more than one");

endmodule
